>>> hw/rtl/jts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types and constants for the six-joint smoothstep move generator.
// ----------------------------------------------------------------------------
package jts_pkg;

  localparam int DEF_ANGLE_BITS    = 16;
  localparam int DEF_DURATION_BITS = 16;

  localparam int JOINT_CNT  = 6;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_BITS = 16;

  // 3.0 in Q2.16, the constant term of 3t^2 - 2t^3 after factoring t^2
  localparam int SHAPE_THREE = 3 * (1 << FRAC_BITS);
  // half of one Q0.16 unit, for round half away from zero
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  localparam logic signed [FIELD_BITS-1:0] FORTY_FIVE_DEG = 16'sd5760;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_SET   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAC,
    ST_SHAPE,
    ST_BLEND,
    ST_POST
  } state_t;

  typedef struct packed {
    logic load;   // latch start, goal and the delta of a new move
    logic go;     // blend with the shaped fraction on the bus
  } lane_ctrl_t;

endpackage

>>> hw/rtl/joint_trajectory_smoothstep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_trajectory_smoothstep
// Timed six-joint move generator with smoothstep easing.
// ----------------------------------------------------------------------------
// One item is in work at a time and each item gives one result beat. Start,
// set, idle ticks and the tick that ends a move go from accept straight to
// the result register. A tick inside a move first passes through the
// bit-a-cycle divider that forms elapsed/duration, then two multiply stages
// of the smoothstep shaper, two stages in the six joint lanes and the merge
// into the angle registers. The result register lets the next item be
// accepted while an earlier result still waits downstream.
module joint_trajectory_smoothstep #(
  parameter int ANGLE_BITS    = jts_pkg::DEF_ANGLE_BITS,
  parameter int DURATION_BITS = jts_pkg::DEF_DURATION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_func,
  input  logic signed [jts_pkg::FIELD_BITS-1:0]  in_target_base,
  input  logic signed [jts_pkg::FIELD_BITS-1:0]  in_target_shoulder,
  input  logic signed [jts_pkg::FIELD_BITS-1:0]  in_target_elbow,
  input  logic signed [jts_pkg::FIELD_BITS-1:0]  in_target_wrist_pitch,
  input  logic signed [jts_pkg::FIELD_BITS-1:0]  in_target_wrist_roll,
  input  logic signed [jts_pkg::FIELD_BITS-1:0]  in_target_gripper,
  input  logic [jts_pkg::FIELD_BITS-1:0]         in_duration,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [jts_pkg::FIELD_BITS-1:0]  out_angle_base,
  output logic signed [jts_pkg::FIELD_BITS-1:0]  out_angle_shoulder,
  output logic signed [jts_pkg::FIELD_BITS-1:0]  out_angle_elbow,
  output logic signed [jts_pkg::FIELD_BITS-1:0]  out_angle_wrist_pitch,
  output logic signed [jts_pkg::FIELD_BITS-1:0]  out_angle_wrist_roll,
  output logic signed [jts_pkg::FIELD_BITS-1:0]  out_angle_gripper,
  output logic                                   out_moving
);
  import jts_pkg::*;

  localparam int SatW = ((ANGLE_BITS > FIELD_BITS) ? ANGLE_BITS : FIELD_BITS) + 1;

  function automatic logic signed [ANGLE_BITS-1:0] sat_angle(
    input logic signed [FIELD_BITS-1:0] v
  );
    logic signed [SatW-1:0] x;
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    x  = {{(SatW-FIELD_BITS){v[FIELD_BITS-1]}}, v};
    hi = {{(SatW-ANGLE_BITS+1){1'b0}}, {(ANGLE_BITS-1){1'b1}}};
    lo = {{(SatW-ANGLE_BITS+1){1'b1}}, {(ANGLE_BITS-1){1'b0}}};
    if (x > hi) begin
      return hi[ANGLE_BITS-1:0];
    end else if (x < lo) begin
      return lo[ANGLE_BITS-1:0];
    end
    return x[ANGLE_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(
    input logic signed [ANGLE_BITS-1:0] a
  );
    logic [SatW-1:0] x;
    x = {{(SatW-ANGLE_BITS){a[ANGLE_BITS-1]}}, a};
    return x[FIELD_BITS-1:0];
  endfunction

  localparam logic signed [ANGLE_BITS-1:0] RST_SHOULDER = sat_angle(FORTY_FIVE_DEG);
  localparam logic signed [ANGLE_BITS-1:0] RST_ELBOW    = sat_angle(-FORTY_FIVE_DEG);

  state_t state_r;
  state_t state_nxt;

  logic signed [ANGLE_BITS-1:0] current_r [JOINT_CNT];
  logic [DURATION_BITS-1:0]     elapsed_r;
  logic [DURATION_BITS-1:0]     length_r;
  logic                         moving_r;

  logic                         out_valid_r;
  logic [FIELD_BITS-1:0]        out_angle_r [JOINT_CNT];
  logic                         out_moving_r;

  logic signed [FIELD_BITS-1:0] tgt_in  [JOINT_CNT];
  logic signed [ANGLE_BITS-1:0] tgt_sat [JOINT_CNT];
  logic signed [ANGLE_BITS-1:0] lane_goal [JOINT_CNT];
  logic signed [ANGLE_BITS-1:0] lane_res  [JOINT_CNT];
  logic [JOINT_CNT-1:0]         lane_done;

  logic                         in_fire;
  logic                         is_start;
  logic                         is_set;
  logic                         is_tick;
  logic [DURATION_BITS-1:0]     elapsed_nxt;
  logic                         move_ends;
  logic                         out_free;

  logic                         div_go;
  logic                         div_done;
  logic [FRAC_BITS-1:0]         frac;
  logic                         sm_go;
  logic                         sm_done;
  logic [FRAC_BITS-1:0]         shaped;
  lane_ctrl_t                   lane_ctrl;
  logic                         merge;
  logic                         post_load;

  assign tgt_in[0] = in_target_base;
  assign tgt_in[1] = in_target_shoulder;
  assign tgt_in[2] = in_target_elbow;
  assign tgt_in[3] = in_target_wrist_pitch;
  assign tgt_in[4] = in_target_wrist_roll;
  assign tgt_in[5] = in_target_gripper;

  always_comb begin
    for (int i = 0; i < JOINT_CNT; i++) begin
      tgt_sat[i] = sat_angle(tgt_in[i]);
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign is_start = (in_func == FUNC_START);
  assign is_set   = (in_func == FUNC_SET);
  assign is_tick  = (in_func == FUNC_TICK) && moving_r;
  assign out_free = !out_valid_r || !out_stall;

  // elapsed count saturates at all ones
  assign elapsed_nxt = (elapsed_r == '1) ? elapsed_r : elapsed_r + DURATION_BITS'(1);
  assign move_ends   = elapsed_nxt >= length_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (is_tick && !move_ends) ? ST_FRAC : ST_POST;
        end
      end
      ST_FRAC: begin
        if (div_done) begin
          state_nxt = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        if (sm_done) begin
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (&lane_done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    div_go         = 1'b0;
    sm_go          = 1'b0;
    lane_ctrl.load = 1'b0;
    lane_ctrl.go   = 1'b0;
    merge          = 1'b0;
    post_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        lane_ctrl.load = in_fire && is_start;
        div_go         = in_fire && is_tick && !move_ends;
      end
      ST_FRAC:  sm_go        = div_done;
      ST_SHAPE: lane_ctrl.go = sm_done;
      ST_BLEND: merge        = &lane_done;
      ST_POST:  post_load    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // merge lanes and item effects into the joint state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINT_CNT; i++) begin
        current_r[i] <= (i == 1) ? RST_SHOULDER :
                        (i == 2) ? RST_ELBOW : '0;
      end
      elapsed_r    <= '0;
      length_r     <= '0;
      moving_r     <= 1'b0;
    end else begin
      if (in_fire && is_start) begin
        length_r  <= DURATION_BITS'(in_duration);
        elapsed_r <= '0;
        moving_r  <= 1'b1;
      end else if (in_fire && is_set) begin
        for (int i = 0; i < JOINT_CNT; i++) begin
          current_r[i] <= tgt_sat[i];
        end
      end else if (in_fire && is_tick) begin
        elapsed_r <= elapsed_nxt;
        if (move_ends) begin
          for (int i = 0; i < JOINT_CNT; i++) begin
            current_r[i] <= lane_goal[i];
          end
          moving_r <= 1'b0;
        end
      end
      if (merge) begin
        for (int i = 0; i < JOINT_CNT; i++) begin
          current_r[i] <= lane_res[i];
        end
      end
    end
  end

  // result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (post_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_load) begin
      for (int i = 0; i < JOINT_CNT; i++) begin
        out_angle_r[i] <= to_field(current_r[i]);
      end
      out_moving_r <= moving_r;
    end
  end

  jts_frac_div #(
    .DURATION_BITS(DURATION_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (elapsed_nxt),
    .den  (length_r),
    .quo  (frac),
    .done (div_done)
  );

  jts_smooth u_smooth (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sm_go),
    .frac  (frac),
    .shaped(shaped),
    .done  (sm_done)
  );

  for (genvar g = 0; g < JOINT_CNT; g++) begin : g_lane
    jts_lane #(
      .ANGLE_BITS(ANGLE_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (lane_ctrl),
      .cur_angle(current_r[g]),
      .tgt_angle(tgt_sat[g]),
      .shaped   (shaped),
      .goal     (lane_goal[g]),
      .blended  (lane_res[g]),
      .done     (lane_done[g])
    );
  end

  assign out_valid             = out_valid_r;
  assign out_angle_base        = out_angle_r[0];
  assign out_angle_shoulder    = out_angle_r[1];
  assign out_angle_elbow       = out_angle_r[2];
  assign out_angle_wrist_pitch = out_angle_r[3];
  assign out_angle_wrist_roll  = out_angle_r[4];
  assign out_angle_gripper     = out_angle_r[5];
  assign out_moving            = out_moving_r;

endmodule

>>> hw/rtl/jts_frac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_frac_div
// Restoring divider: q = floor(num * 2^16 / den) for num < den, one bit a cycle.
// ----------------------------------------------------------------------------
module jts_frac_div #(
  parameter int DURATION_BITS = jts_pkg::DEF_DURATION_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic [DURATION_BITS-1:0]           num,
  input  logic [DURATION_BITS-1:0]           den,
  output logic [jts_pkg::FRAC_BITS-1:0]      quo,
  output logic                               done
);
  import jts_pkg::*;

  localparam int CntW = $clog2(FRAC_BITS + 1);

  logic [DURATION_BITS-1:0] rem_r;
  logic [DURATION_BITS-1:0] den_r;
  logic [FRAC_BITS-1:0]     quo_r;
  logic [CntW-1:0]          cnt_r;
  logic                     done_r;

  logic [DURATION_BITS:0]   shifted;
  logic                     fits;
  logic [DURATION_BITS:0]   diff;

  always_comb begin
    shifted = {rem_r, 1'b0};
    fits    = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      // flag the beat on the last quotient bit
      done_r <= !go && (cnt_r == CntW'(1));
      if (go) begin
        cnt_r <= CntW'(FRAC_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      // remainder stays below den, so the low bits hold it
      rem_r <= fits ? diff[DURATION_BITS-1:0] : shifted[DURATION_BITS-1:0];
      quo_r <= {quo_r[FRAC_BITS-2:0], fits};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

>>> hw/rtl/jts_smooth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_smooth
// Smoothstep shaper: s = floor(t^2 * (3 - 2t)) in Q0.16, two multiply stages.
// ----------------------------------------------------------------------------
module jts_smooth (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [jts_pkg::FRAC_BITS-1:0] frac,
  output logic [jts_pkg::FRAC_BITS-1:0] shaped,
  output logic                          done
);
  import jts_pkg::*;

  localparam int SqW   = 2 * FRAC_BITS;
  localparam int WtW   = FRAC_BITS + 2;
  localparam int ProdW = SqW + WtW;

  logic [SqW-1:0]   sq_r;
  logic [WtW-1:0]   wt_r;
  logic [ProdW-1:0] prod_r;
  logic             sq_v_r;
  logic             prod_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      sq_v_r   <= go;
      prod_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sq_r <= SqW'(frac) * SqW'(frac);
      wt_r <= WtW'(SHAPE_THREE) - WtW'({frac, 1'b0});
    end
    if (sq_v_r) begin
      prod_r <= ProdW'(sq_r) * ProdW'(wt_r);
    end
  end

  // product / 2^32 stays below 2^16
  assign shaped = prod_r[SqW+FRAC_BITS-1:SqW];
  assign done   = prod_v_r;

endmodule

>>> hw/rtl/jts_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_lane
// One joint: holds start and goal of the move and blends between them.
// ----------------------------------------------------------------------------
module jts_lane #(
  parameter int ANGLE_BITS = jts_pkg::DEF_ANGLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  jts_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [ANGLE_BITS-1:0]        cur_angle,
  input  logic signed [ANGLE_BITS-1:0]        tgt_angle,
  input  logic [jts_pkg::FRAC_BITS-1:0]       shaped,
  output logic signed [ANGLE_BITS-1:0]        goal,
  output logic signed [ANGLE_BITS-1:0]        blended,
  output logic                                done
);
  import jts_pkg::*;

  localparam int ProdW = ANGLE_BITS + FRAC_BITS;

  logic signed [ANGLE_BITS-1:0] start_r;
  logic signed [ANGLE_BITS-1:0] goal_r;
  logic                         neg_r;
  logic [ANGLE_BITS-1:0]        mag_r;
  logic [ProdW-1:0]             prod_r;
  logic signed [ANGLE_BITS-1:0] res_r;
  logic                         prod_v_r;
  logic                         done_r;

  logic [ANGLE_BITS:0]          delta;
  logic [ANGLE_BITS:0]          delta_abs;
  logic [ProdW:0]               rounded;
  logic [ANGLE_BITS-1:0]        step;
  logic [ANGLE_BITS:0]          sum;

  always_comb begin
    delta     = {tgt_angle[ANGLE_BITS-1], tgt_angle} - {cur_angle[ANGLE_BITS-1], cur_angle};
    delta_abs = delta[ANGLE_BITS] ? (~delta + (ANGLE_BITS+1)'(1)) : delta;
    rounded   = {1'b0, prod_r} + (ProdW+1)'(ROUND_HALF);
    step      = rounded[ANGLE_BITS+FRAC_BITS-1:FRAC_BITS];
    sum       = neg_r ? ({start_r[ANGLE_BITS-1], start_r} - {1'b0, step})
                      : ({start_r[ANGLE_BITS-1], start_r} + {1'b0, step});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      prod_v_r <= ctrl.go;
      done_r   <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      start_r <= cur_angle;
      goal_r  <= tgt_angle;
      neg_r   <= delta[ANGLE_BITS];
      mag_r   <= delta_abs[ANGLE_BITS-1:0];
    end
    if (ctrl.go) begin
      prod_r <= ProdW'(mag_r) * ProdW'(shaped);
    end
    if (prod_v_r) begin
      // lies between start and goal, so no overflow
      res_r <= sum[ANGLE_BITS-1:0];
    end
  end

  assign goal    = goal_r;
  assign blended = res_r;
  assign done    = done_r;

endmodule
